// File: rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/rbc_pkg.sv
// shared types, constants, substitution tables and field arithmetic
package rbc_pkg;

    localparam int MAX_COLUMNS_DEF = 8;
    localparam int MAX_ROUNDS_DEF  = 14;
    localparam int KEY_HIST        = 8;
    localparam int NC_W            = 4;
    localparam int NR_W            = 4;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd6;

    typedef struct packed {
        logic            decrypt;
        logic            last;
        logic [NC_W-1:0] ncols;
    } round_ctl_t;

    typedef struct packed {
        logic            start;
        logic [NC_W-1:0] nk;
        logic [NC_W-1:0] ncols;
        logic [NR_W-1:0] nr;
    } ks_cfg_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    // row 0 in the top byte
    function automatic logic [31:0] mix_fwd(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] mix_inv(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3;
        a0 = col[31:24];
        a1 = col[23:16];
        a2 = col[15:8];
        a3 = col[7:0];
        return {mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3),
                mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3),
                mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3),
                mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3)};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    // size code to column count, code three acts as 256 bits
    function automatic logic [NC_W-1:0] size_cols(input logic [1:0] code);
        logic [NC_W-1:0] n;
        case (code)
            2'd0:    n = 4'd4;
            2'd1:    n = 4'd6;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/rbc_round.sv
// one cipher round: substitution, row shift, column mix (not in the last round) and key addition
module rbc_round #(
    parameter int MAX_COLUMNS = rbc_pkg::MAX_COLUMNS_DEF
) (
    input  logic [MAX_COLUMNS*32-1:0] state_in,
    input  logic [MAX_COLUMNS*32-1:0] rk,
    input  rbc_pkg::round_ctl_t       ctl,
    output logic [MAX_COLUMNS*32-1:0] state_out
);

    localparam int SW = MAX_COLUMNS * 32;

    logic [SW-1:0] sub_st;
    logic [SW-1:0] sh_st;
    logic [SW-1:0] sh_cand [4:MAX_COLUMNS];

    // byte substitution
    for (genvar b = 0; b < MAX_COLUMNS * 4; b++) begin : g_sub
        assign sub_st[b*8 +: 8] = ctl.decrypt ? rbc_pkg::SBOX_INV[state_in[b*8 +: 8]]
                                              : rbc_pkg::SBOX_FWD[state_in[b*8 +: 8]];
    end

    // row shift for every column count the block can use
    for (genvar n = 4; n <= MAX_COLUMNS; n++) begin : g_width
        for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
            for (genvar r = 0; r < 4; r++) begin : g_row
                localparam int OFF = (n == 8 && r >= 2) ? r + 1 : r;
                localparam int SF  = (c + OFF) % n;
                localparam int SI  = (c + n - OFF) % n;
                if (c < n) begin : g_used
                    assign sh_cand[n][c*32 + 24 - 8*r +: 8] =
                        ctl.decrypt ? sub_st[SI*32 + 24 - 8*r +: 8]
                                    : sub_st[SF*32 + 24 - 8*r +: 8];
                end else begin : g_unused
                    assign sh_cand[n][c*32 + 24 - 8*r +: 8] = sub_st[c*32 + 24 - 8*r +: 8];
                end
            end
        end
    end

    always_comb
    begin
        sh_st = sub_st;
        for (int n = 4; n <= MAX_COLUMNS; n++)
        begin
            if (ctl.ncols == rbc_pkg::NC_W'(n))
            begin
                sh_st = sh_cand[n];
            end
        end
    end

    // column mix and key addition, order differs by direction
    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_mix
        logic [31:0] s_col;
        logic [31:0] k_col;
        assign s_col = sh_st[c*32 +: 32];
        assign k_col = rk[c*32 +: 32];
        assign state_out[c*32 +: 32] =
            ctl.decrypt ? (ctl.last ? (s_col ^ k_col) : rbc_pkg::mix_inv(s_col ^ k_col))
                        : ((ctl.last ? s_col : rbc_pkg::mix_fwd(s_col)) ^ k_col);
    end

endmodule

// File: rtl/rbc_key_store.sv
// key schedule sequencer and round-key store, one word per cycle
module rbc_key_store #(
    parameter int MAX_COLUMNS = rbc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROUNDS  = rbc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rbc_pkg::ks_cfg_t                cfg,
    input  logic [63:0]                     key_words [4],
    input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_row,
    output logic [MAX_COLUMNS*32-1:0]       rk_row,
    output logic                            busy
);

    localparam int RW = $clog2(MAX_ROUNDS + 1);
    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int IW = $clog2(MAX_COLUMNS * (MAX_ROUNDS + 1) + 1);

    typedef enum logic [1:0] {
        KS_IDLE = 2'b01,
        KS_RUN  = 2'b10
    } ks_state_t;

    ks_state_t   state_reg;
    logic [IW-1:0] i_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [2:0]    kpos_reg;
    logic [7:0]    rcon_reg;
    logic [7:0]    rcon_next;
    logic [31:0]   hist_reg [rbc_pkg::KEY_HIST];
    logic [31:0]   store_mem [MAX_ROUNDS+1][MAX_COLUMNS];

    logic [IW-1:0] total;
    logic          loading;
    logic [3:0]    nk_m1;
    logic [31:0]   t_prev;
    logic [31:0]   t_mod;
    logic [31:0]   far_word;
    logic [31:0]   key_word;
    logic [31:0]   new_word;
    logic          last_word;
    logic          col_last;
    logic          kpos_last;

    assign busy      = (state_reg == KS_RUN);
    assign total     = IW'(8'(cfg.ncols) * 8'(cfg.nr + 4'd1));
    assign loading   = (i_reg < IW'(cfg.nk));
    assign nk_m1     = cfg.nk - 4'd1;
    assign t_prev    = hist_reg[0];
    assign far_word  = hist_reg[nk_m1[2:0]];
    assign key_word  = i_reg[0] ? key_words[i_reg[2:1]][31:0] : key_words[i_reg[2:1]][63:32];
    assign last_word = (i_reg == total - IW'(1));
    assign col_last  = (4'(col_reg) == cfg.ncols - 4'd1);
    assign kpos_last = (4'(kpos_reg) == nk_m1);

    always_comb
    begin
        t_mod     = t_prev;
        rcon_next = rcon_reg;
        if (kpos_reg == 3'd0)
        begin
            t_mod     = rbc_pkg::sub_word({t_prev[23:0], t_prev[31:24]}) ^ {rcon_reg, 24'h0};
            rcon_next = rbc_pkg::xt(rcon_reg);
        end
        else if (cfg.nk > 4'd6 && kpos_reg == 3'd4)
        begin
            t_mod = rbc_pkg::sub_word(t_prev);
        end
    end

    assign new_word = loading ? key_word : (far_word ^ t_mod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_RUN;
            i_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            kpos_reg  <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (cfg.start)
        begin
            state_reg <= KS_RUN;
            i_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            kpos_reg  <= '0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            case (state_reg)
                KS_RUN:
                begin
                    i_reg    <= i_reg + IW'(1);
                    kpos_reg <= kpos_last ? 3'd0 : kpos_reg + 3'd1;
                    if (!loading)
                    begin
                        rcon_reg <= rcon_next;
                    end
                    if (col_last)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + RW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                    if (last_word)
                    begin
                        state_reg <= KS_IDLE;
                    end
                end
                KS_IDLE:
                begin
                end
                default:
                begin
                    state_reg <= KS_IDLE;
                end
            endcase
        end
    end

    // store write and history shift
    always_ff @(posedge clk)
    begin
        if (state_reg == KS_RUN && !cfg.start)
        begin
            store_mem[row_reg][col_reg] <= new_word;
            hist_reg[0] <= new_word;
            for (int j = 1; j < rbc_pkg::KEY_HIST; j++)
            begin
                hist_reg[j] <= hist_reg[j-1];
            end
        end
    end

    // registered row read
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            rk_row[c*32 +: 32] <= store_mem[rd_row][c];
        end
    end

endmodule

// File: rtl/rijndael_block_cipher_unit.sv
// rijndael block cipher top level: config registers, round sequencer, output register
// nr is 10 to 14 rounds; the single round unit runs one initial key addition
// plus one round per cycle, and a new item is taken only once the sequencer is idle
// reset: async active low; after reset and after each config write to indexes 0 to 6
// the key schedule fills the round-key store at one word a cycle, input stalled
module rijndael_block_cipher_unit #(
    parameter int MAX_COLUMNS = rbc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROUNDS  = rbc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    // input item channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   block_word_0,
    input  logic [63:0]                   block_word_1,
    input  logic [63:0]                   block_word_2,
    input  logic [63:0]                   block_word_3,
    // result item channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   result_word_0,
    output logic [63:0]                   result_word_1,
    output logic [63:0]                   result_word_2,
    output logic [63:0]                   result_word_3
);

    localparam int SW = MAX_COLUMNS * 32;
    localparam int RW = $clog2(MAX_ROUNDS + 1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INIT  = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } seq_state_t;

    seq_state_t state_reg;

    // config registers
    logic [1:0]  block_size_reg;
    logic [1:0]  key_size_reg;
    logic        decrypt_mode_reg;
    logic [63:0] key_reg [4];

    // per-item control, latched at accept
    logic [rbc_pkg::NR_W-1:0] nr_reg;
    logic [rbc_pkg::NR_W-1:0] rnd_reg;
    logic [rbc_pkg::NC_W-1:0] ncols_reg;
    logic                     dec_reg;
    logic [RW-1:0]            row_reg;
    logic [RW-1:0]            row_next;
    logic                     out_valid_reg;

    // datapath
    logic [SW-1:0] data_reg;
    logic [SW-1:0] load_vec;
    logic [SW-1:0] rk_row;
    logic [SW-1:0] round_out;
    logic [SW-1:0] res_src;
    logic [63:0]   blk [4];
    logic [63:0]   res_word [4];
    logic [63:0]   out_word_reg [4];

    // derived sizes from the current config
    logic [rbc_pkg::NC_W-1:0] sc_blk;
    logic [rbc_pkg::NC_W-1:0] ncols_cur;
    logic [rbc_pkg::NC_W-1:0] nk_cur;
    logic [rbc_pkg::NC_W-1:0] nmax;
    logic [4:0]               nr_wide;
    logic [rbc_pkg::NR_W-1:0] nr_cur;

    logic accept;
    logic cfg_write;
    logic out_free;
    logic round_last;
    logic out_load;
    logic ks_busy;

    rbc_pkg::ks_cfg_t    ks_cfg;
    rbc_pkg::round_ctl_t rnd_ctl;

    // config is always taken, a write to indexes 0 to 6 restarts the schedule
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign in_stall   = (state_reg != ST_IDLE) || ks_busy;
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign round_last = (rnd_reg == nr_reg);
    assign out_load   = ((state_reg == ST_ROUND) && round_last && out_free) ||
                        ((state_reg == ST_DONE) && out_free);

    always_comb
    begin
        sc_blk    = rbc_pkg::size_cols(block_size_reg);
        ncols_cur = (sc_blk > rbc_pkg::NC_W'(MAX_COLUMNS)) ? rbc_pkg::NC_W'(MAX_COLUMNS) : sc_blk;
        nk_cur    = rbc_pkg::size_cols(key_size_reg);
        nmax      = (ncols_cur > nk_cur) ? ncols_cur : nk_cur;
        nr_wide   = 5'(nmax) + 5'd6;
        nr_cur    = (nr_wide > 5'(MAX_ROUNDS)) ? rbc_pkg::NR_W'(MAX_ROUNDS) : nr_wide[3:0];
    end

    always_comb
    begin
        ks_cfg.start = cfg_write && (cfg_index <= rbc_pkg::CFG_KEY_3);
        ks_cfg.nk    = nk_cur;
        ks_cfg.ncols = ncols_cur;
        ks_cfg.nr    = nr_cur;
    end

    assign rnd_ctl.decrypt = dec_reg;
    assign rnd_ctl.last    = round_last;
    assign rnd_ctl.ncols   = ncols_reg;

    rbc_key_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROUNDS  (MAX_ROUNDS)
    ) u_key_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (ks_cfg),
        .key_words (key_reg),
        .rd_row    (row_next),
        .rk_row    (rk_row),
        .busy      (ks_busy)
    );

    rbc_round #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_round (
        .state_in  (data_reg),
        .rk        (rk_row),
        .ctl       (rnd_ctl),
        .state_out (round_out)
    );

    // input words to columns, column c is one half of word c/2, row 0 on top
    assign blk[0] = block_word_0;
    assign blk[1] = block_word_1;
    assign blk[2] = block_word_2;
    assign blk[3] = block_word_3;

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_load
        assign load_vec[c*32 +: 32] = blk[c/2][63 - 32*(c%2) -: 32];
    end

    // result source: straight from the round unit, or the parked final state
    assign res_src = (state_reg == ST_DONE) ? data_reg : round_out;

    for (genvar k = 0; k < 4; k++) begin : g_res
        for (genvar h = 0; h < 2; h++) begin : g_half
            localparam int C = 2*k + h;
            if (C < MAX_COLUMNS) begin : g_col
                // columns beyond the block size read as zero
                assign res_word[k][63 - 32*h -: 32] =
                    (rbc_pkg::NC_W'(C) < ncols_reg) ? res_src[C*32 +: 32] : 32'h0;
            end else begin : g_none
                assign res_word[k][63 - 32*h -: 32] = 32'h0;
            end
        end
    end

    // round-key row to read, data arrives in the next cycle
    always_comb
    begin
        row_next = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = decrypt_mode_reg ? RW'(nr_cur) : '0;
                end
            end
            ST_INIT:
            begin
                row_next = dec_reg ? RW'(row_reg - RW'(1)) : RW'(row_reg + RW'(1));
            end
            ST_ROUND:
            begin
                if (!round_last)
                begin
                    row_next = dec_reg ? RW'(row_reg - RW'(1)) : RW'(row_reg + RW'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            rnd_reg          <= '0;
            row_reg          <= '0;
            nr_reg           <= 4'd10;
            ncols_reg        <= 4'd4;
            dec_reg          <= 1'b0;
            block_size_reg   <= '0;
            key_size_reg     <= '0;
            decrypt_mode_reg <= 1'b0;
            for (int j = 0; j < 4; j++)
            begin
                key_reg[j] <= '0;
            end
        end
        else
        begin
            row_reg <= row_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    rbc_pkg::CFG_BLOCK_SIZE: block_size_reg   <= cfg_data[1:0];
                    rbc_pkg::CFG_KEY_SIZE:   key_size_reg     <= cfg_data[1:0];
                    rbc_pkg::CFG_DECRYPT:    decrypt_mode_reg <= cfg_data[0];
                    rbc_pkg::CFG_KEY_0:      key_reg[0]       <= cfg_data;
                    rbc_pkg::CFG_KEY_1:      key_reg[1]       <= cfg_data;
                    rbc_pkg::CFG_KEY_2:      key_reg[2]       <= cfg_data;
                    rbc_pkg::CFG_KEY_3:      key_reg[3]       <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_INIT;
                        nr_reg    <= nr_cur;
                        ncols_reg <= ncols_cur;
                        dec_reg   <= decrypt_mode_reg;
                    end
                end
                ST_INIT:
                begin
                    rnd_reg   <= 4'd1;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (round_last)
                    begin
                        // park the result when the output register is still full
                        state_reg <= out_free ? ST_IDLE : ST_DONE;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // state word and output payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_reg <= load_vec;
                end
            end
            ST_INIT:
            begin
                // initial key addition
                data_reg <= data_reg ^ rk_row;
            end
            ST_ROUND:
            begin
                data_reg <= round_out;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                out_word_reg[j] <= res_word[j];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_word_0 = out_word_reg[0];
    assign result_word_1 = out_word_reg[1];
    assign result_word_2 = out_word_reg[2];
    assign result_word_3 = out_word_reg[3];

`include "assert_macros.svh"

    // an accepted item always starts with the key addition step
    `ASSERT_NEXT(a_accept_init, in_valid && !in_stall, state_reg == ST_INIT)
    // round counter never passes the latched round count
    `ASSERT_ALWAYS(a_round_bound, (state_reg != ST_ROUND) || (rnd_reg <= nr_reg))
    // the last round leaves the round state
    `ASSERT_NEXT(a_last_exit, (state_reg == ST_ROUND) && (rnd_reg == nr_reg),
                 (state_reg == ST_IDLE) || (state_reg == ST_DONE))
    // a parked result implies a result is on offer next cycle
    `ASSERT_NEXT(a_done_valid, state_reg == ST_DONE, out_valid)

endmodule

// File: bench/testbench.sv
// self-checking testbench for the rijndael block cipher unit
`timescale 1ns / 100ps

module testbench;

    localparam int    PHASES     = 20;
    localparam int    PHASE_ITEMS = 72;
    localparam int    DRAIN_WAIT = 24;       // covers the longest item plus margin
    localparam int    CYCLE_LIMIT = 600000;
    localparam real   HALF_PERIOD = 6.0;
    // aes-128 of the all-zero block under the all-zero key
    localparam logic [255:0] ZERO_KEY_CIPHER =
        {64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 128'h0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] block_word_0 = '0, block_word_1 = '0, block_word_2 = '0, block_word_3 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_word_0, result_word_1, result_word_2, result_word_3;

    rijndael_block_cipher_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .block_word_0(block_word_0), .block_word_1(block_word_1),
        .block_word_2(block_word_2), .block_word_3(block_word_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_word_0(result_word_0), .result_word_1(result_word_1),
        .result_word_2(result_word_2), .result_word_3(result_word_3)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: shadow copy of the config and the expanded key schedule
    // ------------------------------------------------------------------
    logic [1:0]  blk_code = 2'd0, key_code = 2'd0;
    logic        decrypting = 1'b0;
    logic [63:0] key_reg [4] = '{default: '0};
    logic [31:0] sched [120];
    int          nb, nrounds;
    logic [7:0]  cst [4][8];                 // cipher state, row by column

    function automatic int cols_for(logic [1:0] code);
        return (code == 2'd0) ? 4 : (code == 2'd1) ? 6 : 8;
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        return {rbc_pkg::SBOX_FWD[w[31:24]], rbc_pkg::SBOX_FWD[w[23:16]],
                rbc_pkg::SBOX_FWD[w[15:8]], rbc_pkg::SBOX_FWD[w[7:0]]};
    endfunction

    // rebuild the round-key schedule from the shadow config
    function automatic void rebuild_schedule();
        int         nk;
        logic [7:0] rc;
        logic [31:0] t;
        nk = cols_for(key_code);
        nb = cols_for(blk_code);
        nrounds = ((nb > nk) ? nb : nk) + 6;
        rc = 8'h01;
        for (int i = 0; i < nb * (nrounds + 1); i++)
        begin
            if (i < nk)
                sched[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
            else
            begin
                t = sched[i - 1];
                if (i % nk == 0)
                begin
                    t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gf_mul(rc, 8'h02);
                end
                else if (nk > 6 && i % nk == 4)
                    t = sbox_word(t);
                sched[i] = sched[i - nk] ^ t;
            end
        end
    endfunction

    function automatic void add_round_key(int rnd);
        for (int c = 0; c < nb; c++)
            for (int r = 0; r < 4; r++)
                cst[r][c] ^= sched[rnd * nb + c][31 - 8 * r -: 8];
    endfunction

    function automatic void sub_layer(bit inv);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < nb; c++)
                cst[r][c] = inv ? rbc_pkg::SBOX_INV[cst[r][c]] : rbc_pkg::SBOX_FWD[cst[r][c]];
    endfunction

    // eight-column blocks shift rows 2 and 3 by one extra
    function automatic void shift_layer(bit inv);
        logic [7:0] row [8];
        int         off;
        for (int r = 1; r < 4; r++)
        begin
            off = (nb == 8 && r >= 2) ? r + 1 : r;
            for (int c = 0; c < nb; c++)
                if (inv) row[(c + off) % nb] = cst[r][c];
                else     row[c] = cst[r][(c + off) % nb];
            for (int c = 0; c < nb; c++)
                cst[r][c] = row[c];
        end
    endfunction

    function automatic void mix_layer(bit inv);
        logic [7:0] col [4];
        logic [7:0] coef [4];
        logic [7:0] acc;
        coef = inv ? '{8'd14, 8'd11, 8'd13, 8'd9} : '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < nb; c++)
        begin
            for (int r = 0; r < 4; r++) col[r] = cst[r][c];
            for (int r = 0; r < 4; r++)
            begin
                acc = '0;
                for (int k = 0; k < 4; k++) acc ^= gf_mul(coef[(k + 4 - r) % 4], col[k]);
                cst[r][c] = acc;
            end
        end
    endfunction

    // block byte b sits at bits 255-8b of the packed words
    function automatic logic [255:0] rijndael_predict(logic [255:0] blk);
        logic [255:0] res;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 8; c++)
                cst[r][c] = (c < nb) ? blk[255 - 8 * (4 * c + r) -: 8] : 8'h00;
        if (!decrypting)
        begin
            add_round_key(0);
            for (int rnd = 1; rnd <= nrounds; rnd++)
            begin
                sub_layer(1'b0);
                shift_layer(1'b0);
                if (rnd != nrounds) mix_layer(1'b0);
                add_round_key(rnd);
            end
        end
        else
        begin
            add_round_key(nrounds);
            for (int rnd = nrounds; rnd > 0; rnd--)
            begin
                shift_layer(1'b1);
                sub_layer(1'b1);
                add_round_key(rnd - 1);
                if (rnd != 1) mix_layer(1'b1);
            end
        end
        res = '0;
        for (int b = 0; b < 4 * nb; b++)
            res[255 - 8 * b -: 8] = cst[b % 4][b / 4];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    logic [255:0] expected_blocks [$];
    int           error_count = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           stall_mode = 0;
    int           cycle_count = 0;
    logic [7:0]   stall_tick = '0;

    always @(posedge clk)
    begin
        logic [255:0] got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {result_word_0, result_word_1, result_word_2, result_word_3};
            results_seen++;
            if (expected_blocks.size() == 0)
            begin
                $error("unexpected result item %h", got);
                error_count++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                for (int w = 0; w < 4; w++)
                    if (got[255 - 64 * w -: 64] !== want[255 - 64 * w -: 64])
                    begin
                        $error("result_word_%0d: expected %h, actual %h",
                               w, want[255 - 64 * w -: 64], got[255 - 64 * w -: 64]);
                        error_count++;
                    end
            end
        end
    end

    // receiver stall: none, random about a third, or a periodic pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            1:       out_stall <= ($urandom_range(2) == 0);
            2:       out_stall <= (stall_tick[3:2] == 2'b11) || (stall_tick[6:4] == 3'b101);
            default: out_stall <= 1'b0;
        endcase
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit gaps_on = 1'b1;

    // config write while the unit is idle, shadow updated on handshake
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rbc_pkg::CFG_BLOCK_SIZE: blk_code = value[1:0];
            rbc_pkg::CFG_KEY_SIZE:   key_code = value[1:0];
            rbc_pkg::CFG_DECRYPT:    decrypting = value[0];
            rbc_pkg::CFG_KEY_0, rbc_pkg::CFG_KEY_1, rbc_pkg::CFG_KEY_2, rbc_pkg::CFG_KEY_3:
                key_reg[idx - rbc_pkg::CFG_KEY_0] = value;
            default: ;   // indexes past the key words are ignored
        endcase
        rebuild_schedule();
        @(posedge clk);
    endtask

    // one input item in bursts; the prediction is queued on acceptance
    task automatic send_block(logic [255:0] blk);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid     <= 1'b1;
        block_word_0 <= blk[255:192];
        block_word_1 <= blk[191:128];
        block_word_2 <= blk[127:64];
        block_word_3 <= blk[63:0];
        do @(posedge clk); while (in_stall);
        expected_blocks.push_back(rijndael_predict(blk));
        items_sent++;
        burst_left--;
    endtask

    task automatic drain();
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    typedef struct {
        logic [255:0] blk;
        bit           known;
        logic [255:0] want;
    } vector_t;

    vector_t directed [] = '{
        // zero key, zero block: the textbook aes-128 answer
        '{256'h0, 1'b1, ZERO_KEY_CIPHER},
        // bytes past a 128-bit block are ignored
        '{{128'h0, {128{1'b1}}}, 1'b1, ZERO_KEY_CIPHER},
        '{{128'h0, 64'h0123456789abcdef, 64'h8000000000000001}, 1'b1, ZERO_KEY_CIPHER},
        '{{256{1'b1}}, 1'b0, '0},
        '{{64{4'ha}}, 1'b0, '0},
        '{{64{4'h5}}, 1'b0, '0},
        '{{1'b1, 255'h0}, 1'b0, '0},
        '{{127'h0, 1'b1, 128'h0}, 1'b0, '0},
        '{{64'h00112233_44556677, 64'h8899aabb_ccddeeff, 128'h0}, 1'b0, '0}
    };

    initial
    begin
        logic [255:0] blk;
        int           mode;
        rebuild_schedule();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset configuration
        gaps_on = 1'b0;
        foreach (directed[i])
        begin
            if (directed[i].known && rijndael_predict(directed[i].blk) !== directed[i].want)
            begin
                $error("directed row %0d: predictor disagrees with the known answer", i);
                error_count++;
            end
            send_block(directed[i].blk);
            if (directed[i].known)
                expected_blocks[expected_blocks.size() - 1] = directed[i].want;
        end
        in_valid <= 1'b0;
        drain();

        // phases sweep every size pair, both directions, and size code three
        for (int p = 0; p < PHASES; p++)
        begin
            stall_mode = p % 3;
            gaps_on    = (p % 4 != 1);
            if (p < 18)
            begin
                write_reg(rbc_pkg::CFG_BLOCK_SIZE, 64'(p % 3));
                write_reg(rbc_pkg::CFG_KEY_SIZE, 64'((p / 3) % 3));
                write_reg(rbc_pkg::CFG_DECRYPT, 64'(p / 9));
            end
            else
            begin
                write_reg(rbc_pkg::CFG_BLOCK_SIZE, 64'd3);
                write_reg(rbc_pkg::CFG_KEY_SIZE, 64'($urandom_range(3)));
                write_reg(rbc_pkg::CFG_DECRYPT, 64'(p % 2));
            end
            // key extremes in the first phases, random keys afterward
            for (int k = 0; k < 4; k++)
                write_reg(rbc_pkg::CFG_KEY_0 + 3'(k),
                          (p == 0) ? '1 : (p == 1) ? '0 : rand_word());
            if (p == 5)
                write_reg(3'd7, {$urandom, $urandom});

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the pipeline empty once per phase
                if (n == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_blocks.size() != 0) @(posedge clk);
                end
                mode = $urandom_range(9);
                if (mode == 0)
                    blk = (n % 2) ? '1 : '0;
                else
                    blk = {rand_word(), rand_word(), rand_word(), rand_word()};
                send_block(blk);
            end
            in_valid <= 1'b0;
            drain();
        end

        $display("sent %0d blocks over %0d configurations, checked %0d results",
                 items_sent, PHASES + 1, results_seen);
        $display("covered all block and key sizes, both directions, size code three");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rbc_pkg.sv
rtl/rbc_round.sv
rtl/rbc_key_store.sv
rtl/rijndael_block_cipher_unit.sv
bench/testbench.sv
